/* hdl/jtmi_pkg.sv */
// Shared types and constants for the JSON top-level member indexer.
// No dependencies; imported by jtmi_parser, jtmi_result_buf and the top level.
package jtmi_pkg;

    localparam int MAX_DOC_BYTES_DEF = 65536;
    localparam int MAX_DEPTH_DEF     = 255;

    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // "
    localparam logic [7:0] CH_N      = 8'h6E;  // n
    localparam logic [7:0] CH_T      = 8'h74;  // t
    localparam logic [7:0] CH_F      = 8'h66;  // f
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
    localparam logic [7:0] CH_0      = 8'h30;  // 0
    localparam logic [7:0] CH_9      = 8'h39;  // 9

    localparam logic [2:0] KIND_ARRAY  = 3'd0;
    localparam logic [2:0] KIND_OBJECT = 3'd1;
    localparam logic [2:0] KIND_NULL   = 3'd2;
    localparam logic [2:0] KIND_BOOL   = 3'd3;
    localparam logic [2:0] KIND_STRING = 3'd4;
    localparam logic [2:0] KIND_NUMBER = 3'd5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_VALUE = 2'd1;
    localparam logic [1:0] ERR_DEEP  = 2'd2;
    localparam logic [1:0] ERR_LONG  = 2'd3;

    typedef struct packed {
        logic        member_valid;
        logic [15:0] key_offset;
        logic [15:0] key_length;
        logic [15:0] value_offset;
        logic [16:0] value_length;
        logic [2:0]  value_kind;
        logic        doc_end;
        logic [1:0]  error_code;
    } result_t;

endpackage

/* hdl/jtmi_parser.sv */
// Byte-wise parse state of the member indexer: one request updates the state
// and may raise one result. Depends on jtmi_pkg.
module jtmi_parser
    import jtmi_pkg::*;
#(
    parameter int MAX_DOC_BYTES = MAX_DOC_BYTES_DEF,
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam int POS_W   = $clog2(MAX_DOC_BYTES + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int OFF_W   = (POS_W > 16) ? POS_W : 16;
    localparam int LEN_W   = (POS_W > 17) ? POS_W : 17;

    typedef enum logic [8:0] {
        PH_FIRST   = 9'b000000001,
        PH_MEMBER  = 9'b000000010,
        PH_KEY     = 9'b000000100,
        PH_COLON   = 9'b000001000,
        PH_VSTART  = 9'b000010000,
        PH_SCALAR  = 9'b000100000,
        PH_BRACKET = 9'b001000000,
        PH_SKIP    = 9'b010000000,
        PH_DRAIN   = 9'b100000000
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [POS_W-1:0]     key_start_reg, key_start_next;
    logic [15:0]          key_span_reg, key_span_next;
    logic [POS_W-1:0]     value_start_reg, value_start_next;
    logic [2:0]           kind_reg, kind_next;
    logic                 minus_reg, minus_next;

    logic                 member;
    logic [LEN_W-1:0]     vlen;
    logic [LEN_W-1:0]     vlen_incl;
    logic [1:0]           err;
    logic                 is_digit;
    logic [OFF_W-1:0]     key_off_ext;
    logic [OFF_W-1:0]     val_off_ext;
    logic [2:0]           kind_out;
    logic [POS_W-1:0]     vstart_out;

    assign is_digit  = data_byte inside {[CH_0:CH_9]};
    assign vlen_incl = LEN_W'(pos_reg) - LEN_W'(value_start_reg) + LEN_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        depth_next       = depth_reg;
        key_start_next   = key_start_reg;
        key_span_next    = key_span_reg;
        value_start_next = value_start_reg;
        kind_next        = kind_reg;
        minus_next       = minus_reg;
        member           = 1'b0;
        vlen             = '0;
        err              = ERR_NONE;

        if (phase_reg != PH_DRAIN && pos_reg >= POS_W'(MAX_DOC_BYTES))
        begin
            err = ERR_LONG;
        end
        else
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    phase_next = PH_MEMBER;
                end
                PH_MEMBER:
                begin
                    if (data_byte == CH_RBRACE)
                    begin
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        key_start_next = pos_reg + POS_W'(1);
                        phase_next     = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    if (data_byte == CH_QUOTE)
                    begin
                        key_span_next = 16'(pos_reg - key_start_reg);
                        phase_next    = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    phase_next = PH_VSTART;
                end
                PH_VSTART:
                begin
                    value_start_next = pos_reg;
                    minus_next       = 1'b0;
                    if (data_byte == CH_LBRACK || data_byte == CH_LBRACE)
                    begin
                        kind_next  = (data_byte == CH_LBRACK) ? KIND_ARRAY : KIND_OBJECT;
                        depth_next = DEPTH_W'(1);
                        phase_next = PH_BRACKET;
                    end
                    else if (data_byte == CH_N)
                    begin
                        kind_next  = KIND_NULL;
                        phase_next = PH_SCALAR;
                    end
                    else if (data_byte == CH_T || data_byte == CH_F)
                    begin
                        kind_next  = KIND_BOOL;
                        phase_next = PH_SCALAR;
                    end
                    else if (data_byte == CH_QUOTE)
                    begin
                        kind_next  = KIND_STRING;
                        phase_next = PH_SCALAR;
                    end
                    else if (is_digit)
                    begin
                        kind_next  = KIND_NUMBER;
                        phase_next = PH_SCALAR;
                    end
                    else if (data_byte == CH_MINUS)
                    begin
                        kind_next  = KIND_NUMBER;
                        minus_next = 1'b1;
                        phase_next = PH_SCALAR;
                        if (last_byte)
                        begin
                            err = ERR_VALUE;
                        end
                    end
                    else
                    begin
                        err = ERR_VALUE;
                    end
                    if (err == ERR_NONE && last_byte)
                    begin
                        member = 1'b1;
                        vlen   = LEN_W'(1);
                    end
                end
                PH_SCALAR:
                begin
                    if (minus_reg && !is_digit)
                    begin
                        err = ERR_VALUE;
                    end
                    else
                    begin
                        minus_next = 1'b0;
                        if (data_byte == CH_COMMA)
                        begin
                            member     = 1'b1;
                            vlen       = vlen_incl - LEN_W'(1);
                            phase_next = PH_MEMBER;
                        end
                        else if (last_byte)
                        begin
                            member = 1'b1;
                            vlen   = vlen_incl;
                        end
                    end
                end
                PH_BRACKET:
                begin
                    if (data_byte == CH_LBRACK || data_byte == CH_LBRACE)
                    begin
                        if (depth_reg == DEPTH_W'(MAX_DEPTH))
                        begin
                            err = ERR_DEEP;
                        end
                        else
                        begin
                            depth_next = depth_reg + DEPTH_W'(1);
                            if (last_byte)
                            begin
                                member = 1'b1;
                                vlen   = vlen_incl;
                            end
                        end
                    end
                    else if (data_byte == CH_RBRACK || data_byte == CH_RBRACE)
                    begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        // the bracket that closes the value is part of it
                        if (depth_reg == DEPTH_W'(1) || last_byte)
                        begin
                            member = 1'b1;
                            vlen   = vlen_incl;
                        end
                        if (depth_reg == DEPTH_W'(1))
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else if (last_byte)
                    begin
                        member = 1'b1;
                        vlen   = vlen_incl;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_MEMBER;
                end
                default:
                begin
                end
            endcase
        end

        if (err != ERR_NONE)
        begin
            phase_next = PH_DRAIN;
        end

        // hold the value start and kind of this request before the last byte clears them
        kind_out   = kind_next;
        vstart_out = value_start_next;

        // advance the position unless draining; the last byte rearms everything
        if (last_byte)
        begin
            phase_next       = PH_FIRST;
            pos_next         = '0;
            depth_next       = '0;
            key_start_next   = '0;
            key_span_next    = '0;
            value_start_next = '0;
            kind_next        = KIND_ARRAY;
            minus_next       = 1'b0;
        end
        else if (phase_next != PH_DRAIN)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign key_off_ext = OFF_W'(key_start_reg);
    assign val_off_ext = OFF_W'(vstart_out);

    assign res_valid = accept && (member || err != ERR_NONE || last_byte);

    always_comb
    begin
        res.member_valid = member;
        res.key_offset   = member ? key_off_ext[15:0] : 16'd0;
        res.key_length   = member ? key_span_reg : 16'd0;
        res.value_offset = member ? val_off_ext[15:0] : 16'd0;
        res.value_length = member ? vlen[16:0] : 17'd0;
        res.value_kind   = member ? kind_out : KIND_ARRAY;
        res.doc_end      = last_byte;
        res.error_code   = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FIRST;
            pos_reg         <= '0;
            depth_reg       <= '0;
            key_start_reg   <= '0;
            key_span_reg    <= '0;
            value_start_reg <= '0;
            kind_reg        <= KIND_ARRAY;
            minus_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            depth_reg       <= depth_next;
            key_start_reg   <= key_start_next;
            key_span_reg    <= key_span_next;
            value_start_reg <= value_start_next;
            kind_reg        <= kind_next;
            minus_reg       <= minus_next;
        end
    end

endmodule

/* hdl/jtmi_result_buf.sv */
// Output register with a skid stage for the member indexer results.
// Depends on jtmi_pkg for the result record.
module jtmi_result_buf
    import jtmi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            // refill the output from the skid stage first
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

/* hdl/json_top_level_member_indexer.sv */
// Indexes the top-level members of a compact JSON object fed one byte per
// request. Bytes are taken at one per clock; each byte updates the parse state
// in the same cycle, and a result (a finished member, an error or the end of
// the document on tlast) goes into a two-entry output buffer, so the stream
// stalls only when two results wait unread. Each result is registered in the
// buffer before it reaches the master side. Depends on jtmi_pkg, jtmi_parser
// and jtmi_result_buf.
module json_top_level_member_indexer
    import jtmi_pkg::*;
#(
    parameter int MAX_DOC_BYTES = MAX_DOC_BYTES_DEF,
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // key_offset, key_length, value_offset,
                                   // value_length, value_kind, error_code, zero pad
    output logic        m_tuser,   // member_valid
    output logic        m_tlast    // doc_end
);

    logic    accept;
    logic    res_valid;
    logic    space;
    result_t res;
    result_t out_res;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    jtmi_parser #(
        .MAX_DOC_BYTES (MAX_DOC_BYTES),
        .MAX_DEPTH     (MAX_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    jtmi_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {2'b00,
                      out_res.error_code,
                      out_res.value_kind,
                      out_res.value_length,
                      out_res.value_offset,
                      out_res.key_length,
                      out_res.key_offset};
    assign m_tuser = out_res.member_valid;
    assign m_tlast = out_res.doc_end;

endmodule
